/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers shared by the rtl files; empty when SYNTHESIS is set
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif

`endif

/* rtl/wcnp_pkg.sv */
// ----------------------------------------------------------------------------
// wcnp_pkg
// Types and constants of the wide character unsigned number parser
// ----------------------------------------------------------------------------
package wcnp_pkg;

  localparam int CHAR_BITS         = 16;
  localparam int BASE_BITS         = 6;
  localparam int DEF_VALUE_BITS    = 32;
  localparam int DEF_OFFSET_BITS   = 16;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_AUTO  = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT   = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC   = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX   = 6'd16;

  localparam logic [CHAR_BITS-1:0] CHAR_NUL   = 16'h0000;
  localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 16'h0009;
  localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 16'h0020;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 16'h0030;
  localparam logic [CHAR_BITS-1:0] CHAR_NINE  = 16'h0039;
  localparam logic [CHAR_BITS-1:0] CHAR_UC_A  = 16'h0041;
  localparam logic [CHAR_BITS-1:0] CHAR_UC_X  = 16'h0058;
  localparam logic [CHAR_BITS-1:0] CHAR_UC_Z  = 16'h005A;
  localparam logic [CHAR_BITS-1:0] CHAR_LC_A  = 16'h0061;
  localparam logic [CHAR_BITS-1:0] CHAR_LC_X  = 16'h0078;
  localparam logic [CHAR_BITS-1:0] CHAR_LC_Z  = 16'h007A;

  typedef enum logic [2:0] {
    PH_SKIP      = 3'd0,
    PH_AUTO_ZERO = 3'd1,
    PH_HEX_ZERO  = 3'd2,
    PH_DIGITS    = 3'd3,
    PH_STOP      = 3'd4
  } phase_t;

  // control part of the parse state
  typedef struct packed {
    phase_t               phase;
    logic [BASE_BITS-1:0] base;
  } ctl_t;

endpackage

/* rtl/wcnp_in_stage.sv */
// ----------------------------------------------------------------------------
// wcnp_in_stage
// Input register: holds one item until the parse step takes it
// ----------------------------------------------------------------------------
module wcnp_in_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wcnp_pkg::CHAR_BITS-1:0] char_code,
  input  logic                           first_char,
  input  logic                           take,
  output logic                           q_valid,
  output logic [wcnp_pkg::CHAR_BITS-1:0] q_char,
  output logic                           q_first
);

  logic load;

  // stall only while the held item is not being taken
  assign in_stall = q_valid && !take;
  assign load     = in_valid && !in_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (load) begin
      q_valid <= 1'b1;
    end else if (take) begin
      q_valid <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load) begin
      q_char  <= char_code;
      q_first <= first_char;
    end
  end

endmodule

/* rtl/wcnp_step.sv */
// ----------------------------------------------------------------------------
// wcnp_step
// Next parse state for one character: phase, radix, value and offsets
// ----------------------------------------------------------------------------
module wcnp_step #(
  parameter int VALUE_BITS  = wcnp_pkg::DEF_VALUE_BITS,
  parameter int OFFSET_BITS = wcnp_pkg::DEF_OFFSET_BITS
) (
  input  logic [wcnp_pkg::CHAR_BITS-1:0] char_code,
  input  logic                           first_char,
  input  logic [wcnp_pkg::BASE_BITS-1:0] number_base,
  input  wcnp_pkg::ctl_t                 ctl,
  input  logic [VALUE_BITS-1:0]          acc,
  input  logic [OFFSET_BITS-1:0]         consumed,
  input  logic [OFFSET_BITS-1:0]         pos,
  output wcnp_pkg::ctl_t                 ctl_next,
  output logic [VALUE_BITS-1:0]          acc_next,
  output logic [OFFSET_BITS-1:0]         consumed_next,
  output logic [OFFSET_BITS-1:0]         pos_next
);

  localparam int PROD_BITS = VALUE_BITS + wcnp_pkg::BASE_BITS;

  logic                           is_digit;
  logic [wcnp_pkg::BASE_BITS-1:0] digit;
  logic                           is_blank;
  logic                           is_x;
  logic                           is_nul;
  logic                           is_zero;

  // character classes and digit value
  always_comb begin
    is_digit = 1'b1;
    digit    = '0;
    if (char_code >= wcnp_pkg::CHAR_ZERO && char_code <= wcnp_pkg::CHAR_NINE) begin
      digit = wcnp_pkg::BASE_BITS'(char_code - wcnp_pkg::CHAR_ZERO);
    end else if (char_code >= wcnp_pkg::CHAR_LC_A && char_code <= wcnp_pkg::CHAR_LC_Z) begin
      digit = wcnp_pkg::BASE_BITS'(char_code - wcnp_pkg::CHAR_LC_A + 16'd10);
    end else if (char_code >= wcnp_pkg::CHAR_UC_A && char_code <= wcnp_pkg::CHAR_UC_Z) begin
      digit = wcnp_pkg::BASE_BITS'(char_code - wcnp_pkg::CHAR_UC_A + 16'd10);
    end else begin
      is_digit = 1'b0;
    end
  end

  assign is_blank = (char_code == wcnp_pkg::CHAR_SPACE) || (char_code == wcnp_pkg::CHAR_TAB);
  assign is_x     = (char_code == wcnp_pkg::CHAR_LC_X) || (char_code == wcnp_pkg::CHAR_UC_X);
  assign is_nul   = (char_code == wcnp_pkg::CHAR_NUL);
  assign is_zero  = (char_code == wcnp_pkg::CHAR_ZERO);

  // phase update and digit accumulation
  always_comb begin
    wcnp_pkg::ctl_t         cur;
    logic [VALUE_BITS-1:0]  acc_cur;
    logic [OFFSET_BITS-1:0] cons_cur;
    logic [OFFSET_BITS-1:0] pos_cur;
    logic [OFFSET_BITS-1:0] pos_inc;
    logic                   take;
    logic [PROD_BITS-1:0]   prod;

    // a start mark clears the parse before this character is handled
    if (first_char) begin
      cur.phase = wcnp_pkg::PH_SKIP;
      cur.base  = '0;
      acc_cur   = '0;
      cons_cur  = '0;
      pos_cur   = '0;
    end else begin
      cur      = ctl;
      acc_cur  = acc;
      cons_cur = consumed;
      pos_cur  = pos;
    end

    // saturating position step
    pos_inc = (&pos_cur) ? pos_cur : pos_cur + 1'b1;

    ctl_next      = cur;
    acc_next      = acc_cur;
    consumed_next = cons_cur;
    take          = 1'b0;

    unique case (cur.phase)
      wcnp_pkg::PH_SKIP: begin
        if (is_blank) begin
          consumed_next = pos_inc;
        end else if (is_nul) begin
          ctl_next.phase = wcnp_pkg::PH_STOP;
        end else if (number_base == wcnp_pkg::BASE_AUTO) begin
          if (is_zero) begin
            consumed_next  = pos_inc;
            ctl_next.phase = wcnp_pkg::PH_AUTO_ZERO;
          end else begin
            ctl_next.base  = wcnp_pkg::BASE_DEC;
            ctl_next.phase = wcnp_pkg::PH_DIGITS;
            take           = 1'b1;
          end
        end else if (number_base == wcnp_pkg::BASE_HEX && is_zero) begin
          ctl_next.base  = wcnp_pkg::BASE_HEX;
          consumed_next  = pos_inc;
          ctl_next.phase = wcnp_pkg::PH_HEX_ZERO;
        end else begin
          ctl_next.base  = number_base;
          ctl_next.phase = wcnp_pkg::PH_DIGITS;
          take           = 1'b1;
        end
      end
      wcnp_pkg::PH_AUTO_ZERO: begin
        ctl_next.phase = wcnp_pkg::PH_DIGITS;
        if (is_x) begin
          ctl_next.base = wcnp_pkg::BASE_HEX;
          consumed_next = pos_inc;
        end else begin
          ctl_next.base = wcnp_pkg::BASE_OCT;
          if (is_nul) begin
            ctl_next.phase = wcnp_pkg::PH_STOP;
          end else begin
            take = 1'b1;
          end
        end
      end
      wcnp_pkg::PH_HEX_ZERO: begin
        ctl_next.phase = wcnp_pkg::PH_DIGITS;
        if (is_x) begin
          consumed_next = pos_inc;
        end else if (is_nul) begin
          ctl_next.phase = wcnp_pkg::PH_STOP;
        end else begin
          take = 1'b1;
        end
      end
      wcnp_pkg::PH_DIGITS: begin
        if (is_nul) begin
          ctl_next.phase = wcnp_pkg::PH_STOP;
        end else begin
          take = 1'b1;
        end
      end
      default: begin
        ctl_next = cur;
      end
    endcase

    // one multiply-add with the radix now in force
    prod = PROD_BITS'(acc_cur) * PROD_BITS'(ctl_next.base);
    if (take) begin
      if (!is_digit || digit >= ctl_next.base) begin
        ctl_next.phase = wcnp_pkg::PH_STOP;
      end else begin
        acc_next      = prod[VALUE_BITS-1:0] + VALUE_BITS'(digit);
        consumed_next = pos_inc;
      end
    end

    // position advances while the parse is live
    pos_next = (ctl_next.phase == wcnp_pkg::PH_STOP) ? pos_cur : pos_inc;
  end

endmodule

/* rtl/wide_char_unsigned_number_parser_core.sv */
// ----------------------------------------------------------------------------
// wide_char_unsigned_number_parser_core
// Streaming strtoul-style parser over 16-bit characters
// ----------------------------------------------------------------------------
// One character per item, one result per item. The block takes a new item
// in every cycle unless the output is stalled. Each item passes the input
// register and then goes through the parse step into the state
// registers that drive the result ports. The rate is set by the parse step,
// a single multiply-add of the running value by the radix plus the phase
// update, which closes on itself each cycle. number_base is latched at the
// first non-blank character of a string.
module wide_char_unsigned_number_parser_core #(
  parameter int VALUE_BITS  = wcnp_pkg::DEF_VALUE_BITS,
  parameter int OFFSET_BITS = wcnp_pkg::DEF_OFFSET_BITS
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write_en,
  input  logic [wcnp_pkg::BASE_BITS-1:0] cfg_write_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [wcnp_pkg::CHAR_BITS-1:0] char_code,
  input  logic                           first_char,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [VALUE_BITS-1:0]          parsed_value,
  output logic [OFFSET_BITS-1:0]         end_offset,
  output logic                           stopped
);

`include "assert_macros.svh"

  logic [wcnp_pkg::BASE_BITS-1:0] number_base;
  logic                           q_valid;
  logic [wcnp_pkg::CHAR_BITS-1:0] q_char;
  logic                           q_first;
  logic                           take;
  wcnp_pkg::ctl_t                 ctl;
  wcnp_pkg::ctl_t                 ctl_next;
  logic [VALUE_BITS-1:0]          acc;
  logic [VALUE_BITS-1:0]          acc_next;
  logic [OFFSET_BITS-1:0]         consumed;
  logic [OFFSET_BITS-1:0]         consumed_next;
  logic [OFFSET_BITS-1:0]         pos;
  logic [OFFSET_BITS-1:0]         pos_next;

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      number_base <= wcnp_pkg::BASE_RESET;
    end else if (cfg_write_en) begin
      number_base <= cfg_write_data;
    end
  end

  // the held item moves on when the result slot is free or being taken
  assign take = q_valid && (!out_valid || !out_stall);

  wcnp_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .char_code  (char_code),
    .first_char (first_char),
    .take       (take),
    .q_valid    (q_valid),
    .q_char     (q_char),
    .q_first    (q_first)
  );

  wcnp_step #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_step (
    .char_code     (q_char),
    .first_char    (q_first),
    .number_base   (number_base),
    .ctl           (ctl),
    .acc           (acc),
    .consumed      (consumed),
    .pos           (pos),
    .ctl_next      (ctl_next),
    .acc_next      (acc_next),
    .consumed_next (consumed_next),
    .pos_next      (pos_next)
  );

  // parse state, which is also the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl.phase <= wcnp_pkg::PH_SKIP;
      ctl.base  <= '0;
      acc       <= '0;
      consumed  <= '0;
      pos       <= '0;
    end else if (take) begin
      ctl      <= ctl_next;
      acc      <= acc_next;
      consumed <= consumed_next;
      pos      <= pos_next;
    end
  end

  // result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  assign parsed_value = acc;
  assign end_offset   = consumed;
  assign stopped      = (ctl.phase == wcnp_pkg::PH_STOP);

  // a stopped parse ignores characters until a start mark
  `ASSERT_NEXT(a_stop_holds, clk, rst, take && stopped && !q_first, $stable(acc) && $stable(consumed) && $stable(pos))
  // the end pointer never runs ahead of the position
  `ASSERT_PROP(a_offset_le_pos, clk, rst, consumed <= pos)
  // every item taken from the input register shows up as a result
  `ASSERT_NEXT(a_take_gives_result, clk, rst, take, out_valid)

endmodule
